/* src/chacha20_stream_cipher_unit_assert.svh */
// assertion macros used by the checker of this block
`ifndef CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH

// clocked check, switched off while reset is low
`define CC20_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cc20 check failed");

// clocked check that also holds during reset
`define CC20_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cc20 reset check failed");

`endif

/* src/cc20_pkg.sv */
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEPS         = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(STEPS);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int DATA_W  = 64;
    localparam int CNT_W   = 4;
    localparam int WORDS   = 8;
    localparam int WORD_W  = $clog2(WORDS);
    localparam int TDATA_W = 72;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] MAX_BYTES = 4'd8;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_NONCE0 = 3'd4,
        CFG_NONCE1 = 3'd5,
        CFG_ICTR   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_lo;
        logic [31:0]      nonce_hi;
        logic [31:0]      init_ctr;
    } t_cfg;

    typedef struct packed {
        logic              new_blk;
        logic [31:0]       ctr;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ROUND,
        ST_ADD
    } t_state;

    typedef logic [15:0][31:0] t_words;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_quad;

    // one half of a quarter round: first half rotates 16/12, second 8/7
    function automatic t_quad half_qr(input t_quad q, input logic second);
        t_quad r;
        logic [31:0] dx;
        logic [31:0] bx;
        r.a = q.a + q.b;
        dx  = q.d ^ r.a;
        r.d = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        r.c = q.c + r.d;
        bx  = q.b ^ r.c;
        r.b = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        return r;
    endfunction

    function automatic t_words init_state(input t_cfg cfg, input logic [31:0] ctr);
        t_words w;
        w[0] = SIGMA0;
        w[1] = SIGMA1;
        w[2] = SIGMA2;
        w[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            w[4 + 2 * i] = cfg.key[i][31:0];
            w[5 + 2 * i] = cfg.key[i][63:32];
        end
        w[12] = ctr;
        w[13] = cfg.nonce_lo[31:0];
        w[14] = cfg.nonce_lo[63:32];
        w[15] = cfg.nonce_hi;
        return w;
    endfunction

endpackage

/* src/cc20_fifo.sv */
module cc20_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cc20_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output cc20_pkg::t_item o_item
);
    import cc20_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* src/cc20_front.sv */
module cc20_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_first,
    input  logic [cc20_pkg::DATA_W-1:0]   i_data,
    input  logic [cc20_pkg::CNT_W-1:0]    i_cnt,
    input  logic [31:0]                   i_init_ctr,
    input  logic                          i_q_ready,
    output logic                          o_ready,
    output logic                          o_push,
    output cc20_pkg::t_item               o_item
);
    import cc20_pkg::*;

    logic [31:0]       r_bctr, n_bctr;
    logic [WORD_W-1:0] r_off, n_off;
    logic [31:0]       ctr_eff;
    logic [WORD_W-1:0] off_eff;
    logic [CNT_W-1:0]  cnt_sat;
    logic              uses_ks;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        ctr_eff = i_first ? i_init_ctr : r_bctr;
        off_eff = i_first ? '0 : r_off;
        cnt_sat = (i_cnt > MAX_BYTES) ? MAX_BYTES : i_cnt;
        uses_ks = (i_cnt != '0);

        o_item.new_blk = uses_ks && (off_eff == '0);
        o_item.ctr     = ctr_eff;
        o_item.word    = off_eff;
        o_item.cnt     = cnt_sat;
        o_item.data    = i_data;

        n_bctr = r_bctr;
        n_off  = r_off;
        if (o_push) begin
            // an empty item still takes the restart but leaves the keystream alone
            n_bctr = o_item.new_blk ? ctr_eff + 32'd1 : ctr_eff;
            n_off  = uses_ks ? off_eff + 1'b1 : off_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bctr <= '0;
            r_off  <= '0;
        end else begin
            r_bctr <= n_bctr;
            r_off  <= n_off;
        end
    end

endmodule

/* src/cc20_back.sv */
module cc20_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cc20_pkg::t_cfg                i_cfg,
    input  logic                          i_head_valid,
    input  cc20_pkg::t_item               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cc20_pkg::DATA_W-1:0]   o_data,
    output logic [cc20_pkg::CNT_W-1:0]    o_cnt
);
    import cc20_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              r_fresh;
    logic [31:0]       r_bctr;
    t_words            r_x, n_x;
    logic [DATA_W-1:0] r_ks [WORDS];
    logic              r_ov;
    logic [DATA_W-1:0] r_od, n_od;
    logic [CNT_W-1:0]  r_oc;

    logic   need_gen;
    logic   load;
    logic   rnd_en;
    logic   add_en;
    logic   last_step;
    t_words init_w;
    logic [DATA_W-1:0] ks_word;

    assign need_gen  = i_head.new_blk && !r_fresh;
    assign last_step = (r_step == STEP_W'(STEPS - 1));
    assign init_w    = init_state(i_cfg, r_bctr);
    assign ks_word   = r_ks[i_head.word];

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_cnt   = r_oc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_head_valid && need_gen) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (last_step) n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        load   = 1'b0;
        o_pop  = 1'b0;
        rnd_en = 1'b0;
        add_en = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                load  = i_head_valid && need_gen;
                o_pop = i_head_valid && !need_gen && (!r_ov || i_ready);
            end
            ST_ROUND: rnd_en = 1'b1;
            ST_ADD:   add_en = 1'b1;
            default: ;
        endcase
    end

    // four quarter rounds side by side, column or diagonal from step bit 1
    always_comb begin
        logic diag;
        logic second;
        logic [3:0] ia, ib, ic, id;
        t_quad q;
        t_quad r;
        diag   = r_step[1];
        second = r_step[0];
        n_x    = r_x;
        for (int i = 0; i < 4; i++) begin
            ia  = 4'(i);
            ib  = 4'(4 + ((i + int'(diag)) & 3));
            ic  = 4'(8 + ((i + 2 * int'(diag)) & 3));
            id  = 4'(12 + ((i + 3 * int'(diag)) & 3));
            q.a = r_x[ia];
            q.b = r_x[ib];
            q.c = r_x[ic];
            q.d = r_x[id];
            r   = half_qr(q, second);
            n_x[ia] = r.a;
            n_x[ib] = r.b;
            n_x[ic] = r.c;
            n_x[id] = r.d;
        end
    end

    always_comb begin
        for (int b = 0; b < WORDS; b++) begin
            n_od[8*b +: 8] = (CNT_W'(b) < i_head.cnt) ?
                             (i_head.data[8*b +: 8] ^ ks_word[8*b +: 8]) : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_step  <= '0;
            r_fresh <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_step <= '0;
            end else if (rnd_en) begin
                r_step <= r_step + 1'b1;
            end
            if (add_en) begin
                r_fresh <= 1'b1;
            end else if (o_pop) begin
                r_fresh <= 1'b0;
            end
            if (o_pop) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bctr <= i_head.ctr;
            r_x    <= init_state(i_cfg, i_head.ctr);
        end else if (rnd_en) begin
            r_x <= n_x;
        end
        if (add_en) begin
            for (int w = 0; w < WORDS; w++) begin
                r_ks[w] <= {r_x[2*w+1] + init_w[2*w+1], r_x[2*w] + init_w[2*w]};
            end
        end
        if (o_pop) begin
            r_od <= n_od;
            r_oc <= i_head.cnt;
        end
    end

endmodule

/* src/chacha20_stream_cipher_unit.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: data_in, byte_count; tuser: first_word
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: data_out, valid_bytes
// cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// one item per cycle while words of the current keystream block remain and m_axis
// takes the results; a new block is built in the half-quarter-round unit (load, round
// steps, add), and no item is taken from the queue until it is done
// reset is synchronous, active low; the keystream store is not cleared
// a four-entry queue parts input from block generation, an output register parts
// the back end from m_axis, so either side may stall alone
module chacha20_stream_cipher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_in [63:0], byte_count [67:64], zero [71:68]
    input  logic [cc20_pkg::TDATA_W-1:0]    s_axis_tdata,
    // first_word [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_out [63:0], valid_bytes [67:64], zero [71:68]
    output logic [cc20_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                     i_cfg_data
);
    import cc20_pkg::*;

    t_cfg  r_cfg;
    t_item push_item;
    t_item head_item;
    logic  push;
    logic  q_ready;
    logic  head_valid;
    logic  pop;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY0:   r_cfg.key[0]   <= i_cfg_data;
                CFG_KEY1:   r_cfg.key[1]   <= i_cfg_data;
                CFG_KEY2:   r_cfg.key[2]   <= i_cfg_data;
                CFG_KEY3:   r_cfg.key[3]   <= i_cfg_data;
                CFG_NONCE0: r_cfg.nonce_lo <= i_cfg_data;
                CFG_NONCE1: r_cfg.nonce_hi <= i_cfg_data[31:0];
                CFG_ICTR:   r_cfg.init_ctr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cc20_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_first    (s_axis_tuser),
        .i_data     (s_axis_tdata[DATA_W-1:0]),
        .i_cnt      (s_axis_tdata[DATA_W +: CNT_W]),
        .i_init_ctr (r_cfg.init_ctr),
        .i_q_ready  (q_ready),
        .o_ready    (s_axis_tready),
        .o_push     (push),
        .o_item     (push_item)
    );

    cc20_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    cc20_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (out_data),
        .o_cnt        (out_cnt)
    );

    assign m_axis_tdata = {(TDATA_W - DATA_W - CNT_W)'(0), out_cnt, out_data};

endmodule

/* src/cc20_checker.sv */
`include "chacha20_stream_cipher_unit_assert.svh"

module cc20_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [63:0] i_cfg_data
);

    // a held result keeps its payload
    `CC20_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // reset leaves no result pending
    `CC20_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid)

    // an empty item gives an all-zero result
    `CC20_ASSERT(a_zero_item, m_axis_tvalid && m_axis_tdata[67:64] == 4'd0 |-> m_axis_tdata[71:0] == 72'd0)

    // with a count of one, bytes past the first are zero
    `CC20_ASSERT(a_one_byte, m_axis_tvalid && m_axis_tdata[67:64] == 4'd1 |-> m_axis_tdata[63:8] == 56'd0)

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (.*);

/* bench/chacha20_stream_cipher_unit_chk.sv */
module chacha20_stream_cipher_unit_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // data_in [63:0], byte_count [67:64], zero [71:68]
    input  logic [cc20_pkg::TDATA_W-1:0]   s_axis_tdata,
    // first_word [0]
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // data_out [63:0], valid_bytes [67:64], zero [71:68]
    input  logic [cc20_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import cc20_pkg::*;

    typedef logic [15:0][31:0] t_block_words;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
    } t_cipher_word;

    logic [63:0]  key_q [4];
    logic [63:0]  nonce_lo_q;
    logic [31:0]  nonce_hi_q;
    logic [31:0]  init_ctr_q;
    logic [31:0]  blk_ctr;
    logic [2:0]   word_pos;
    t_block_words ks_blk;
    t_cipher_word expected_words [$];
    int           errors = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_block_words quarter_mix(input t_block_words x,
                                                 input int a, input int b,
                                                 input int c, input int d);
        x[a] = x[a] + x[b];
        x[d] = rotl32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d];
        x[b] = rotl32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b];
        x[d] = rotl32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d];
        x[b] = rotl32(x[b] ^ x[c], 7);
        return x;
    endfunction

    // keystream block for the current key and nonce at the given counter
    function automatic t_block_words chacha_block(input logic [31:0] ctr);
        t_block_words st;
        t_block_words x;
        st[0] = SIGMA0;
        st[1] = SIGMA1;
        st[2] = SIGMA2;
        st[3] = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            st[4 + 2 * k] = key_q[k][31:0];
            st[5 + 2 * k] = key_q[k][63:32];
        end
        st[12] = ctr;
        st[13] = nonce_lo_q[31:0];
        st[14] = nonce_lo_q[63:32];
        st[15] = nonce_hi_q;
        x = st;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            x = quarter_mix(x, 0, 4, 8, 12);
            x = quarter_mix(x, 1, 5, 9, 13);
            x = quarter_mix(x, 2, 6, 10, 14);
            x = quarter_mix(x, 3, 7, 11, 15);
            x = quarter_mix(x, 0, 5, 10, 15);
            x = quarter_mix(x, 1, 6, 11, 12);
            x = quarter_mix(x, 2, 7, 8, 13);
            x = quarter_mix(x, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++)
            x[k] = x[k] + st[k];
        return x;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_cipher_word got;
        t_cipher_word want;
        logic [3:0]   n;
        logic [63:0]  ks;
        logic [63:0]  mask;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++)
                key_q[k] = '0;
            nonce_lo_q = '0;
            nonce_hi_q = '0;
            init_ctr_q = '0;
            blk_ctr    = '0;
            word_pos   = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY0:   key_q[0]   = i_cfg_data;
                    CFG_KEY1:   key_q[1]   = i_cfg_data;
                    CFG_KEY2:   key_q[2]   = i_cfg_data;
                    CFG_KEY3:   key_q[3]   = i_cfg_data;
                    CFG_NONCE0: nonce_lo_q = i_cfg_data;
                    CFG_NONCE1: nonce_hi_q = i_cfg_data[31:0];
                    CFG_ICTR:   init_ctr_q = i_cfg_data[31:0];
                    default: ;
                endcase
            end

            // results first: a result can never belong to an item taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.data   = m_axis_tdata[63:0];
                got.nbytes = m_axis_tdata[67:64];
                if (expected_words.size() == 0) begin
                    report_mismatch("result with nothing pending", got.data, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.data != want.data)
                        report_mismatch("data_out", got.data, want.data);
                    if (got.nbytes != want.nbytes)
                        report_mismatch("valid_bytes", 64'(got.nbytes), 64'(want.nbytes));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    blk_ctr  = init_ctr_q;
                    word_pos = '0;
                end
                n = s_axis_tdata[67:64];
                if (n == 4'd0) begin
                    want.data   = '0;
                    want.nbytes = '0;
                end else begin
                    if (n > MAX_BYTES)
                        n = MAX_BYTES;
                    if (word_pos == 3'd0) begin
                        ks_blk  = chacha_block(blk_ctr);
                        blk_ctr = blk_ctr + 32'd1;
                    end
                    ks = {ks_blk[2 * int'(word_pos) + 1], ks_blk[2 * int'(word_pos)]};
                    word_pos = word_pos + 3'd1;
                    // any short word still eats a whole keystream word
                    mask = (n == MAX_BYTES) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                    want.data   = (s_axis_tdata[63:0] ^ ks) & mask;
                    want.nbytes = n;
                end
                expected_words.push_back(want);
            end
        end
        o_pending = expected_words.size();
        o_errors  = errors;
    end

endmodule

/* bench/chacha20_stream_cipher_unit_tb.sv */
module chacha20_stream_cipher_unit_tb;
    import cc20_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0]          i_cfg_data = '0;

    int   err_count;
    int   pending_count;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   items_sent = 0;
    int   settings_used = 0;

    logic [63:0] set_key [4];
    logic [63:0] set_nonce_lo;
    logic [63:0] set_nonce_hi;
    logic [63:0] set_ictr;

    chacha20_stream_cipher_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    chacha20_stream_cipher_unit_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (err_count),
        .o_pending     (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("run exceeded its time limit");
        $display("RESULT: ERROR");
        $finish;
    end

    // output side: short random stalls, or one long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 20) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic first, input logic [63:0] data,
                             input logic [3:0] cnt);
        if (idle_on && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= first;
        s_axis_tdata  <= {4'b0000, cnt, data};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // stop offering and wait until every pending result is back
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > 20000) begin
                $display("timeout with %0d results outstanding", pending_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic write_settings();
        write_reg(CFG_KEY0, set_key[0]);
        write_reg(CFG_KEY1, set_key[1]);
        write_reg(CFG_KEY2, set_key[2]);
        write_reg(CFG_KEY3, set_key[3]);
        write_reg(CFG_NONCE0, set_nonce_lo);
        write_reg(CFG_NONCE1, set_nonce_hi);
        write_reg(CFG_ICTR, set_ictr);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int phase_count;
        int msg_len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // well-known test key and nonce, counter one
        set_key[0]   = 64'h0706050403020100;
        set_key[1]   = 64'h0f0e0d0c0b0a0908;
        set_key[2]   = 64'h1716151413121110;
        set_key[3]   = 64'h1f1e1d1c1b1a1918;
        set_nonce_lo = 64'h4a00000009000000;
        set_nonce_hi = 64'h0;
        set_ictr     = 64'h1;
        write_settings();
        send_word(1'b1, 64'h0, 4'd8);
        send_word(1'b0, 64'h0, 4'd8);
        send_word(1'b0, '1, 4'd8);
        send_word(1'b0, rand_data(), 4'd1);     // short word mid-message
        send_word(1'b0, rand_data(), 4'd0);     // no keystream used
        send_word(1'b0, rand_data(), 4'd9);     // oversize counts saturate
        send_word(1'b0, rand_data(), 4'd15);
        send_word(1'b0, rand_data(), 4'd8);
        send_word(1'b0, rand_data(), 4'd8);
        send_word(1'b0, rand_data(), 4'd8);     // runs into the second block
        send_word(1'b1, rand_data(), 4'd0);     // restart with an empty word
        send_word(1'b0, rand_data(), 4'd5);
        wait_drained();

        // all ones everywhere, counter wraps after the first block
        for (int k = 0; k < 4; k++)
            set_key[k] = '1;
        set_nonce_lo = '1;
        set_nonce_hi = '1;
        set_ictr     = '1;
        write_settings();
        for (int k = 0; k < 10; k++)
            send_word(k == 0, rand_data(), (k == 9) ? 4'd3 : 4'd8);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            idle_on = (ph < 10);
            for (int k = 0; k < 4; k++)
                set_key[k] = pick_value();
            set_nonce_lo = pick_value();
            set_nonce_hi = pick_value();
            case ($urandom_range(0, 3))
                0:       set_ictr = {$urandom, 32'h0};
                1:       set_ictr = {$urandom, 32'hffffffff};
                2:       set_ictr = {$urandom, 32'hffffffff - $urandom_range(0, 3)};
                default: set_ictr = {$urandom, $urandom};
            endcase
            write_settings();
            if (ph == 3)
                hold_req = 1'b1;
            phase_count = 0;
            while (phase_count < 150) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_word(1'($urandom_range(0, 1)), rand_data(),
                              4'($urandom_range(0, 15)));
                    phase_count++;
                end else begin
                    msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                          : $urandom_range(1, 12);
                    for (int k = 0; k < msg_len; k++)
                        send_word(k == 0, rand_data(),
                                  (k == msg_len - 1) ? 4'($urandom_range(1, 8)) : 4'd8);
                    phase_count += msg_len;
                end
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        $display("%0d items sent over %0d key, nonce and counter settings", items_sent,
                 settings_used);
        $display("covered restarts, short and empty words, oversize counts, counter wrap");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
